[rtl/bptc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the barometric compensation block.
// No dependencies; the interfaces and the top level use it.
package bptc_pkg;

  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned CALIB_W  = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TEMP_W   = 32;
  localparam int unsigned PRESS_W  = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TEMP_CALIB    = 2'd0;
  localparam cfg_idx_t CFG_PRESS_CALIB_A = 2'd1;
  localparam cfg_idx_t CFG_PRESS_CALIB_B = 2'd2;
  localparam cfg_idx_t CFG_PRESS_CALIB_C = 2'd3;

  localparam logic MODE_TEMP  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

endpackage

[rtl/bptc_if.sv]
`timescale 1ns / 1ps
// Handshake channel interfaces for samples, results and calibration writes.
// Depends on bptc_pkg for field widths.
interface bptc_sample_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [bptc_pkg::SAMPLE_W-1:0] raw_sample;
  modport source (output valid, mode, raw_sample, input ready);
  modport sink   (input valid, mode, raw_sample, output ready);
endinterface

interface bptc_result_if;
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [bptc_pkg::TEMP_W-1:0]  temperature_centi;
  logic [bptc_pkg::PRESS_W-1:0] pressure_q24_8;
  logic                         divide_by_zero;
  modport source (output valid, result_kind, temperature_centi, pressure_q24_8,
                  divide_by_zero, input ready);
  modport sink   (input valid, result_kind, temperature_centi, pressure_q24_8,
                  divide_by_zero, output ready);
endinterface

interface bptc_cfg_if;
  logic                         valid;
  logic                         ready;
  bptc_pkg::cfg_idx_t           index;
  logic [bptc_pkg::CALIB_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/baro_temp_pressure_compensate.sv]
`timescale 1ns / 1ps
// Temperature item: 3 bit-serial multiplies and the steps T0 to T4. Pressure item: 10 such
// multiplies and a restoring divide of 64 quotient bits; a zero divisor ends the item before
// the divide. A multiply ends early once its multiplier operand runs out of ones. One item is
// in flight at a time; the next sample is taken the cycle after the result is loaded, and a
// stalled result holds the block in its output step.
// Synchronous active-high reset clears calibration, fine temperature and the handshake state.
module baro_temp_pressure_compensate (
  input  logic           clk,
  input  logic           rst,
  bptc_sample_if.sink    sample,
  bptc_result_if.source  result,
  bptc_cfg_if.sink       cfg
);

  // The sequencer walks a list of steps. Most steps consume the previous product held
  // in acc; each stores what it needs, then starts a multiply, the divide, a step or output.
  typedef enum logic [2:0] {S_IDLE, S_CALC, S_MUL, S_DIV, S_OUT} state_t;
  typedef enum logic [4:0] {
    T0, T1, T2, T3, T4,
    P0, P1, P2, P3, P4, P5, P6, P7, P8, P9, P10, P11, P12
  } step_t;

  state_t state;
  step_t  step;

  logic [bptc_pkg::CALIB_W-1:0]  temp_calib, press_calib_a, press_calib_b, press_calib_c;
  logic [31:0]                   fine;
  logic [bptc_pkg::SAMPLE_W-1:0] adc;

  // Shift-add multiplier: one bit of mb per cycle, product modulo 2^64 in acc.
  logic [63:0] acc, ma, mb;
  // Restoring divider on magnitudes: one quotient bit per cycle.
  logic [63:0] rem, quo, dvs;
  logic [5:0]  cnt;
  logic        q_neg;

  logic [63:0] r_a, r_m1, r_v2, r_den, r_q, r_x, r_s;

  logic        st_kind, st_flag;
  logic [31:0] st_temp, st_press;

  logic        out_valid, out_kind, out_flag;
  logic [31:0] out_temp, out_press;

  // Calibration words.
  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = temp_calib[15:0];
  assign t2 = temp_calib[31:16];
  assign t3 = temp_calib[47:32];
  assign p1 = press_calib_a[15:0];
  assign p2 = press_calib_a[31:16];
  assign p3 = press_calib_a[47:32];
  assign p4 = press_calib_b[15:0];
  assign p5 = press_calib_b[31:16];
  assign p6 = press_calib_b[47:32];
  assign p7 = press_calib_c[15:0];
  assign p8 = press_calib_c[31:16];
  assign p9 = press_calib_c[47:32];

  // Datapath terms used by the sequencer steps.
  logic [31:0] d1, d2, t_s, t_fine, t_x5;
  logic [63:0] f_v1, p_x, p_den, p_num, p_q, p_h, p_fin;
  logic [64:0] rem_sh, diff;

  always_comb begin
    d1     = {15'd0, adc[19:3]} - {15'd0, t1, 1'b0};
    d2     = {16'd0, adc[19:4]} - {16'd0, t1};
    t_s    = 32'($signed(acc[31:0]) >>> 12);
    t_fine = r_a[31:0] + 32'($signed(acc[31:0]) >>> 14);
    t_x5   = {fine[29:0], 2'b00} + fine + 32'd128;
    f_v1   = {{32{fine[31]}}, fine} - 64'd128000;
    p_x    = r_m1 + {acc[51:0], 12'd0} + (64'd1 << 47);
    p_den  = 64'($signed(acc) >>> 33);
    p_num  = ({43'd0, 21'd1048576 - {1'b0, adc}} << 31) - r_v2;
    p_q    = q_neg ? (64'd0 - quo) : quo;
    p_h    = 64'($signed(p_q) >>> 13);
    p_fin  = 64'($signed(r_s) >>> 8) + {{44{p7[15]}}, p7, 4'd0};
    rem_sh = {rem, quo[63]};
    diff   = rem_sh - {1'b0, dvs};
  end

  assign sample.ready            = (state == S_IDLE);
  assign cfg.ready               = 1'b1;
  assign result.valid            = out_valid;
  assign result.result_kind      = out_kind;
  assign result.temperature_centi = out_temp;
  assign result.pressure_q24_8   = out_press;
  assign result.divide_by_zero   = out_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= T0;
      out_valid     <= 1'b0;
      fine          <= '0;
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          bptc_pkg::CFG_TEMP_CALIB:    temp_calib    <= cfg.data;
          bptc_pkg::CFG_PRESS_CALIB_A: press_calib_a <= cfg.data;
          bptc_pkg::CFG_PRESS_CALIB_B: press_calib_b <= cfg.data;
          bptc_pkg::CFG_PRESS_CALIB_C: press_calib_c <= cfg.data;
          default: ;
        endcase
      end

      // The output step loads the next result itself when the old one leaves.
      if (out_valid && result.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            adc    <= sample.raw_sample;
            step   <= (sample.mode == bptc_pkg::MODE_PRESS) ? P0 : T0;
            state  <= S_CALC;
          end
        end

        S_MUL: begin
          if (mb == 64'd0) begin
            state <= S_CALC;
          end else begin
            if (mb[0]) acc <= acc + ma;
            ma <= {ma[62:0], 1'b0};
            mb <= {1'b0, mb[63:1]};
          end
        end

        S_DIV: begin
          rem <= diff[64] ? rem_sh[63:0] : diff[63:0];
          quo <= {quo[62:0], ~diff[64]};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) state <= S_CALC;
        end

        S_OUT: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_kind  <= st_kind;
            out_temp  <= st_temp;
            out_press <= st_press;
            out_flag  <= st_flag;
            state     <= S_IDLE;
          end
        end

        S_CALC: begin
          // Every step picks where the sequencer goes next; most launch a multiply.
          acc <= '0;
          case (step)
            // Temperature formula, 32-bit wrapping.
            T0: begin
              ma    <= {{32{d1[31]}}, d1};
              mb    <= {{48{t2[15]}}, t2};
              step  <= T1;
              state <= S_MUL;
            end
            T1: begin
              r_a   <= {32'd0, 32'($signed(acc[31:0]) >>> 11)};
              ma    <= {{32{d2[31]}}, d2};
              mb    <= {{32{d2[31]}}, d2};
              step  <= T2;
              state <= S_MUL;
            end
            T2: begin
              ma    <= {{32{t_s[31]}}, t_s};
              mb    <= {{48{t3[15]}}, t3};
              step  <= T3;
              state <= S_MUL;
            end
            T3: begin
              fine  <= t_fine;
              step  <= T4;
              state <= S_CALC;
            end
            T4: begin
              st_kind  <= bptc_pkg::MODE_TEMP;
              st_temp  <= 32'($signed(t_x5) >>> 8);
              st_press <= '0;
              st_flag  <= 1'b0;
              state    <= S_OUT;
            end
            // Pressure formula, 64-bit wrapping.
            P0: begin
              r_a   <= f_v1;
              ma    <= f_v1;
              mb    <= f_v1;
              step  <= P1;
              state <= S_MUL;
            end
            P1: begin
              r_m1  <= acc;
              ma    <= acc;
              mb    <= {{48{p6[15]}}, p6};
              step  <= P2;
              state <= S_MUL;
            end
            P2: begin
              r_v2  <= acc;
              ma    <= r_a;
              mb    <= {{48{p5[15]}}, p5};
              step  <= P3;
              state <= S_MUL;
            end
            P3: begin
              r_v2  <= r_v2 + {acc[46:0], 17'd0} + {{13{p4[15]}}, p4, 35'd0};
              ma    <= r_m1;
              mb    <= {{48{p3[15]}}, p3};
              step  <= P4;
              state <= S_MUL;
            end
            P4: begin
              r_m1  <= 64'($signed(acc) >>> 8);
              ma    <= r_a;
              mb    <= {{48{p2[15]}}, p2};
              step  <= P5;
              state <= S_MUL;
            end
            P5: begin
              ma    <= p_x;
              mb    <= {48'd0, p1};
              step  <= P6;
              state <= S_MUL;
            end
            P6: begin
              r_den <= p_den;
              if (p_den == 64'd0) begin
                st_kind  <= bptc_pkg::MODE_PRESS;
                st_temp  <= '0;
                st_press <= '0;
                st_flag  <= 1'b1;
                state    <= S_OUT;
              end else begin
                ma    <= p_num;
                mb    <= 64'd3125;
                step  <= P7;
                state <= S_MUL;
              end
            end
            P7: begin
              // Signed division on magnitudes; the sign is restored afterwards.
              q_neg <= acc[63] ^ r_den[63];
              quo   <= acc[63] ? (64'd0 - acc) : acc;
              dvs   <= r_den[63] ? (64'd0 - r_den) : r_den;
              rem   <= '0;
              cnt   <= 6'd63;
              step  <= P8;
              state <= S_DIV;
            end
            P8: begin
              r_q   <= p_q;
              ma    <= p_h;
              mb    <= p_h;
              step  <= P9;
              state <= S_MUL;
            end
            P9: begin
              ma    <= acc;
              mb    <= {{48{p9[15]}}, p9};
              step  <= P10;
              state <= S_MUL;
            end
            P10: begin
              r_x   <= 64'($signed(acc) >>> 25);
              ma    <= {{48{p8[15]}}, p8};
              mb    <= r_q;
              step  <= P11;
              state <= S_MUL;
            end
            P11: begin
              r_s   <= r_q + r_x + 64'($signed(acc) >>> 19);
              step  <= P12;
              state <= S_CALC;
            end
            P12: begin
              st_kind <= bptc_pkg::MODE_PRESS;
              st_temp <= '0;
              st_flag <= 1'b0;
              if (p_fin[63]) begin
                st_press <= '0;
              end else if (p_fin[63:32] != 32'd0) begin
                st_press <= 32'hFFFF_FFFF;
              end else begin
                st_press <= p_fin[31:0];
              end
              state <= S_OUT;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/bptc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the barometric compensation block, bound to the top level.
// Depends on bptc_pkg and the top level's channel ports.
module bptc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [31:0] press,
  input logic        flag
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new sample taken while a transaction is in progress");

  a_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == bptc_pkg::MODE_TEMP) |-> (press == 32'd0) && !flag)
    else $error("temperature result carries pressure fields");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && flag |-> (press == 32'd0) && (result_kind == bptc_pkg::MODE_PRESS))
    else $error("zero divisor without zero pressure");

endmodule

bind baro_temp_pressure_compensate bptc_checker u_bptc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .result_kind (result.result_kind),
  .press       (result.pressure_q24_8),
  .flag        (result.divide_by_zero)
);

[bench/baro_comp_checker.sv]
`timescale 1ns / 1ps
// Checker for the barometric compensation block: watches the sample, result and
// calibration channels, predicts each result and compares. Depends on bptc_pkg, bptc_if.
module baro_comp_checker (
  input  logic          clk,
  input  logic          rst,
  bptc_sample_if        sample,
  bptc_result_if        result,
  bptc_cfg_if           cfg,
  output int            fail_count,
  output int            pending
);

  typedef struct packed {
    logic        kind;
    logic [31:0] temp;
    logic [31:0] press;
    logic        dbz;
  } comp_result_t;

  logic [47:0] cal_t, cal_pa, cal_pb, cal_pc;
  logic [31:0] fine_t;
  comp_result_t expected_q[$];

  function automatic logic signed [63:0] sword(input logic [47:0] r, input int k);
    return 64'(signed'(r[16*k +: 16]));
  endfunction

  function automatic logic signed [63:0] trunc_div(input logic signed [63:0] n,
                                                   input logic signed [63:0] d);
    logic [63:0] an, ad, q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  task automatic compensate(input logic mode, input logic [19:0] adc,
                            output comp_result_t r);
    logic signed [31:0] t1, t2, t3, d1, d2, tv1, tv2, tf;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, h;
    r = '0;
    r.kind = mode;
    if (mode == bptc_pkg::MODE_TEMP) begin
      t1 = {16'd0, cal_t[15:0]};
      t2 = 32'(signed'(cal_t[31:16]));
      t3 = 32'(signed'(cal_t[47:32]));
      d1 = {15'd0, adc[19:3]} - (t1 <<< 1);
      tv1 = (d1 * t2) >>> 11;
      d2 = {16'd0, adc[19:4]} - t1;
      tv2 = (((d2 * d2) >>> 12) * t3) >>> 14;
      tf = tv1 + tv2;
      fine_t = tf;
      r.temp = (tf * 32'sd5 + 32'sd128) >>> 8;
    end else begin
      p1 = {48'd0, cal_pa[15:0]};
      p2 = sword(cal_pa, 1); p3 = sword(cal_pa, 2);
      p4 = sword(cal_pb, 0); p5 = sword(cal_pb, 1); p6 = sword(cal_pb, 2);
      p7 = sword(cal_pc, 0); p8 = sword(cal_pc, 1); p9 = sword(cal_pc, 2);
      v1 = 64'(signed'(fine_t)) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
        r.dbz = 1'b1;
      end else begin
        p = 64'sd1048576 - {44'd0, adc};
        p = trunc_div(((p <<< 31) - v2) * 64'sd3125, v1);
        h = p >>> 13;
        v1 = (p9 * h * h) >>> 25;
        v2 = (p8 * p) >>> 19;
        p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
        if (p[63]) r.press = '0;
        else if (p > 64'sh0FFFFFFFF) r.press = '1;
        else r.press = p[31:0];
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    comp_result_t r, e;
    if (rst) begin
      cal_t <= '0; cal_pa <= '0; cal_pb <= '0; cal_pc <= '0;
      fine_t = '0;
      fail_count <= 0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          bptc_pkg::CFG_TEMP_CALIB:    cal_t  <= cfg.data;
          bptc_pkg::CFG_PRESS_CALIB_A: cal_pa <= cfg.data;
          bptc_pkg::CFG_PRESS_CALIB_B: cal_pb <= cfg.data;
          bptc_pkg::CFG_PRESS_CALIB_C: cal_pc <= cfg.data;
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) begin
        compensate(sample.mode, sample.raw_sample, r);
        expected_q.push_back(r);
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", {31'd0, result.result_kind}, 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (result.result_kind !== e.kind)
            report("kind", {31'd0, result.result_kind}, {31'd0, e.kind});
          if (result.temperature_centi !== e.temp)
            report("temperature", result.temperature_centi, e.temp);
          if (result.pressure_q24_8 !== e.press)
            report("pressure", result.pressure_q24_8, e.press);
          if (result.divide_by_zero !== e.dbz)
            report("divide_by_zero", {31'd0, result.divide_by_zero}, {31'd0, e.dbz});
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

[bench/baro_temp_pressure_compensate_test.sv]
`timescale 1ns / 1ps
// Top of the bench for the barometric compensation block: makes the stimulus,
// drives the channels and gives the verdict. Depends on bptc_pkg, bptc_if, the checker.
module baro_temp_pressure_compensate_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  bit   hold_results = 1'b0;

  bptc_sample_if s_if();
  bptc_result_if r_if();
  bptc_cfg_if    c_if();

  always #5 clk = ~clk;

  baro_temp_pressure_compensate uut (.clk(clk), .rst(rst), .sample(s_if),
                                     .result(r_if), .cfg(c_if));
  baro_comp_checker chk (.clk(clk), .rst(rst), .sample(s_if), .result(r_if), .cfg(c_if),
                         .fail_count(fail_count), .pending(pending));

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Result side: random ready, with one long hold-off requested by the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      r_if.ready <= 1'b0;
    end else if (hold_results) begin
      r_if.ready <= 1'b0;
    end else begin
      r_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: a correct run never goes this long without a transaction;
  // a pressure item and the longest stall are both far shorter.
  always @(posedge clk) begin
    if ((s_if.valid && s_if.ready) || (r_if.valid && r_if.ready) ||
        (c_if.valid && c_if.ready) || rst || hold_results)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input bptc_pkg::cfg_idx_t idx, input logic [47:0] value);
    c_if.valid <= 1'b1;
    c_if.index <= idx;
    c_if.data  <= value;
    do @(posedge clk); while (!c_if.ready);
    c_if.valid <= 1'b0;
  endtask

  task automatic send_sample(input logic mode, input logic [19:0] raw, input bit gaps);
    int g;
    s_if.valid <= 1'b1;
    s_if.mode <= mode;
    s_if.raw_sample <= raw;
    do @(posedge clk); while (!s_if.ready);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Waits until the checker has seen every expected result; the count it reads is registered.
  task automatic wait_empty();
    s_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Every expected result must have arrived, then the block is given its latency
  // to settle before any register write.
  task automatic drain();
    wait_empty();
    repeat (1000) @(posedge clk);
  endtask

  // Calibration near the published typical values, randomized around them.
  function automatic logic [15:0] near(input int base, input int spread);
    return 16'(base + $urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic load_typical();
    write_reg(bptc_pkg::CFG_TEMP_CALIB,
              {near(50, 40), near(26435, 3000), near(27504, 3000)});
    write_reg(bptc_pkg::CFG_PRESS_CALIB_A,
              {near(-10, 30) , near(-10685, 2000), near(36477, 4000)});
    write_reg(bptc_pkg::CFG_PRESS_CALIB_B, {near(-7, 20), near(-39, 40), near(2855, 2000)});
    write_reg(bptc_pkg::CFG_PRESS_CALIB_C,
              {near(6000, 3000), near(-14600, 2000), near(15500, 200)});
  endtask

  task automatic load_random();
    write_reg(bptc_pkg::CFG_TEMP_CALIB, 48'({$urandom, $urandom}));
    write_reg(bptc_pkg::CFG_PRESS_CALIB_A, 48'({$urandom, $urandom}));
    write_reg(bptc_pkg::CFG_PRESS_CALIB_B, 48'({$urandom, $urandom}));
    write_reg(bptc_pkg::CFG_PRESS_CALIB_C, 48'({$urandom, $urandom}));
  endtask

  function automatic logic [19:0] rand_raw();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 20'h00000;
    if (sel == 1) return 20'hFFFFF;
    if (sel < 6) return 20'($urandom_range(300000, 600000));
    return 20'($urandom);
  endfunction

  initial begin
    int phase;
    s_if.valid = 1'b0; s_if.mode = 1'b0; s_if.raw_sample = '0;
    c_if.valid = 1'b0; c_if.index = '0; c_if.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pressure before any temperature, with all calibration still zero:
    // the divisor is zero, so the flag must rise.
    send_sample(bptc_pkg::MODE_PRESS, 20'h80000, 1'b0);
    send_sample(bptc_pkg::MODE_TEMP, 20'h00000, 1'b0);
    send_sample(bptc_pkg::MODE_TEMP, 20'hFFFFF, 1'b0);
    drain();

    // Extremes of every register.
    write_reg(bptc_pkg::CFG_TEMP_CALIB, 48'hFFFF_FFFF_FFFF);
    write_reg(bptc_pkg::CFG_PRESS_CALIB_A, 48'hFFFF_FFFF_FFFF);
    write_reg(bptc_pkg::CFG_PRESS_CALIB_B, 48'hFFFF_FFFF_FFFF);
    write_reg(bptc_pkg::CFG_PRESS_CALIB_C, 48'hFFFF_FFFF_FFFF);
    send_sample(bptc_pkg::MODE_TEMP, 20'hFFFFF, 1'b0);
    send_sample(bptc_pkg::MODE_PRESS, 20'h00000, 1'b0);
    send_sample(bptc_pkg::MODE_PRESS, 20'hFFFFF, 1'b0);
    send_sample(bptc_pkg::MODE_TEMP, 20'h00000, 1'b0);
    send_sample(bptc_pkg::MODE_PRESS, 20'h55555, 1'b0);
    drain();
    write_reg(bptc_pkg::CFG_TEMP_CALIB, 48'h8000_8000_0000);
    write_reg(bptc_pkg::CFG_PRESS_CALIB_A, 48'h8000_8000_FFFF);
    write_reg(bptc_pkg::CFG_PRESS_CALIB_B, 48'h7FFF_7FFF_7FFF);
    write_reg(bptc_pkg::CFG_PRESS_CALIB_C, 48'h7FFF_8000_7FFF);
    send_sample(bptc_pkg::MODE_TEMP, 20'hAAAAA, 1'b0);
    send_sample(bptc_pkg::MODE_PRESS, 20'h12345, 1'b0);
    send_sample(bptc_pkg::MODE_PRESS, 20'hFFFFF, 1'b0);
    drain();

    // Typical calibration: saturation low and high show up at the ends of the range.
    load_typical();
    send_sample(bptc_pkg::MODE_TEMP, 20'd519888, 1'b0);
    send_sample(bptc_pkg::MODE_PRESS, 20'd415148, 1'b0);
    send_sample(bptc_pkg::MODE_PRESS, 20'h00000, 1'b0);
    send_sample(bptc_pkg::MODE_PRESS, 20'hFFFFF, 1'b0);
    send_sample(bptc_pkg::MODE_TEMP, 20'hFFFFF, 1'b0);
    send_sample(bptc_pkg::MODE_PRESS, 20'd300000, 1'b0);
    drain();

    // Long receiver hold-off while the sender keeps offering: the block fills
    // and must stall its sample input.
    hold_results = 1'b1;
    fork
      begin
        for (int i = 0; i < 6; i++) send_sample(1'($urandom), rand_raw(), 1'b0);
      end
      begin
        repeat (3000) @(posedge clk);
        hold_results = 1'b0;
      end
    join
    drain();

    // Random phases, mostly near-typical calibration with some fully random sets.
    for (phase = 0; phase < 17; phase++) begin
      if (phase % 4 == 3) load_random();
      else load_typical();
      for (int i = 0; i < 100; i++) begin
        if (phase % 5 == 4 && $urandom_range(0, 3) == 0)
          send_sample(bptc_pkg::MODE_PRESS, rand_raw(), 1'b1);
        else
          send_sample(($urandom_range(0, 2) != 0) ? bptc_pkg::MODE_PRESS : bptc_pkg::MODE_TEMP,
                      rand_raw(), (i % 25) < 18);
        // Occasionally the sender waits for every result before going on.
        if ($urandom_range(0, 49) == 0) begin
          wait_empty();
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
